// ===== hw/rtl/itl_pkg.sv =====
`default_nettype none

package itl_pkg;

   localparam int unsigned KindWidth = 4;
   localparam int unsigned CharWidth = 8;

   typedef enum logic [KindWidth-1:0] {
      KIND_END     = 4'd0,
      KIND_LBRACK  = 4'd1,
      KIND_RBRACK  = 4'd2,
      KIND_EQUALS  = 4'd3,
      KIND_NEWLINE = 4'd4,
      KIND_ID      = 4'd5,
      KIND_NUM     = 4'd6,
      KIND_STRING  = 4'd7,
      KIND_BADCHAR = 4'd8,
      KIND_UNTERM  = 4'd9
   } kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_ID       = 3'd1,
      MODE_NUM      = 3'd2,
      MODE_STR_OPEN = 3'd3,
      MODE_STR_BODY = 3'd4,
      MODE_ERROR    = 3'd5
   } mode_type;

   typedef enum logic {
      OP_DATA = 1'b0,
      OP_END  = 1'b1
   } op_type;

   localparam logic [CharWidth-1:0] CH_TAB    = 8'h09;
   localparam logic [CharWidth-1:0] CH_LF     = 8'h0A;
   localparam logic [CharWidth-1:0] CH_CR     = 8'h0D;
   localparam logic [CharWidth-1:0] CH_SPACE  = 8'h20;
   localparam logic [CharWidth-1:0] CH_QUOTE  = 8'h22;
   localparam logic [CharWidth-1:0] CH_DOT    = 8'h2E;
   localparam logic [CharWidth-1:0] CH_EQUALS = 8'h3D;
   localparam logic [CharWidth-1:0] CH_LBRACK = 8'h5B;
   localparam logic [CharWidth-1:0] CH_RBRACK = 8'h5D;

   typedef struct packed {
      kind_type               kind;
      logic [CharWidth-1:0]   ch;
      logic                   ch_valid;
      logic                   done;
   } result_type;

   // outcome of lexing one item: up to two results
   typedef struct packed {
      result_type res0;
      result_type res1;
      logic [1:0] count;
      mode_type   next_mode;
   } step_type;

   function automatic result_type make_result(kind_type kind, logic [CharWidth-1:0] ch,
                                              logic ch_valid, logic done);
      result_type r;
      r.kind     = kind;
      r.ch       = ch;
      r.ch_valid = ch_valid;
      r.done     = done;
      return r;
   endfunction

   function automatic logic is_alpha(logic [CharWidth-1:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(logic [CharWidth-1:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/itl_stream_if.sv =====
`default_nettype none

interface itl_req_if;
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic [itl_pkg::CharWidth-1:0] byte_in;

   modport source (output valid, output op, output byte_in, input ready);
   modport sink (input valid, input op, input byte_in, output ready);
endinterface

interface itl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [itl_pkg::KindWidth-1:0] token_kind;
   logic [itl_pkg::CharWidth-1:0] char_out;
   logic                          char_valid;
   logic                          token_done;

   modport source (output valid, output token_kind, output char_out, output char_valid,
                   output token_done, input ready);
   modport sink (input valid, input token_kind, input char_out, input char_valid,
                 input token_done, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/itl_classify.sv =====
`default_nettype none

module itl_classify (
   input  var itl_pkg::mode_type              mode,
   input  var logic                           op,
   input  var logic [itl_pkg::CharWidth-1:0]  byte_in,
   output var itl_pkg::step_type              step
);

   typedef struct packed {
      logic                 emit;
      itl_pkg::result_type  res;
      itl_pkg::mode_type    mode;
   } idle_type;

   idle_type            idle;
   itl_pkg::result_type close_res;
   itl_pkg::result_type end_res;

   // a byte seen with no token open
   always_comb begin
      idle.emit = 1'b1;
      idle.mode = itl_pkg::MODE_IDLE;
      idle.res  = itl_pkg::make_result(itl_pkg::KIND_BADCHAR, byte_in, 1'b1, 1'b1);
      case (byte_in)
         itl_pkg::CH_SPACE, itl_pkg::CH_TAB, itl_pkg::CH_CR: begin
            idle.emit = 1'b0;
         end
         itl_pkg::CH_LF: begin
            idle.res.kind = itl_pkg::KIND_NEWLINE;
         end
         itl_pkg::CH_LBRACK: begin
            idle.res.kind = itl_pkg::KIND_LBRACK;
         end
         itl_pkg::CH_RBRACK: begin
            idle.res.kind = itl_pkg::KIND_RBRACK;
         end
         itl_pkg::CH_EQUALS: begin
            idle.res.kind = itl_pkg::KIND_EQUALS;
         end
         itl_pkg::CH_QUOTE: begin
            idle.emit = 1'b0;
            idle.mode = itl_pkg::MODE_STR_OPEN;
         end
         default: begin
            if (itl_pkg::is_alpha(byte_in)) begin
               idle.res.kind = itl_pkg::KIND_ID;
               idle.res.done = 1'b0;
               idle.mode     = itl_pkg::MODE_ID;
            end else if (itl_pkg::is_digit(byte_in) || byte_in == itl_pkg::CH_DOT) begin
               idle.res.kind = itl_pkg::KIND_NUM;
               idle.res.done = 1'b0;
               idle.mode     = itl_pkg::MODE_NUM;
            end else begin
               idle.mode = itl_pkg::MODE_ERROR;
            end
         end
      endcase
   end

   always_comb begin
      end_res   = itl_pkg::make_result(itl_pkg::KIND_END, '0, 1'b0, 1'b1);
      close_res = end_res;
      step      = '0;
      step.next_mode = mode;
      if (op == itl_pkg::OP_END) begin
         step.next_mode = itl_pkg::MODE_IDLE;
         step.res0      = end_res;
         step.count     = 2'd1;
         if (mode == itl_pkg::MODE_ID || mode == itl_pkg::MODE_NUM ||
             mode == itl_pkg::MODE_STR_OPEN || mode == itl_pkg::MODE_STR_BODY) begin
            if (mode == itl_pkg::MODE_ID) begin
               close_res.kind = itl_pkg::KIND_ID;
            end else if (mode == itl_pkg::MODE_NUM) begin
               close_res.kind = itl_pkg::KIND_NUM;
            end else begin
               close_res.kind = itl_pkg::KIND_UNTERM;
            end
            step.res0  = close_res;
            step.res1  = end_res;
            step.count = 2'd2;
         end
      end else begin
         case (mode)
            itl_pkg::MODE_ID, itl_pkg::MODE_NUM: begin
               close_res.kind = (mode == itl_pkg::MODE_ID) ? itl_pkg::KIND_ID
                                                          : itl_pkg::KIND_NUM;
               if ((mode == itl_pkg::MODE_ID && itl_pkg::is_alpha(byte_in)) ||
                   (mode == itl_pkg::MODE_NUM &&
                    (itl_pkg::is_digit(byte_in) || byte_in == itl_pkg::CH_DOT))) begin
                  step.res0  = itl_pkg::make_result(close_res.kind, byte_in, 1'b1, 1'b0);
                  step.count = 2'd1;
               end else begin
                  // close the token, then lex the byte from scratch
                  step.res0      = close_res;
                  step.res1      = idle.res;
                  step.count     = idle.emit ? 2'd2 : 2'd1;
                  step.next_mode = idle.mode;
               end
            end
            itl_pkg::MODE_STR_OPEN: begin
               step.res0      = itl_pkg::make_result(itl_pkg::KIND_STRING, byte_in, 1'b1, 1'b0);
               step.count     = 2'd1;
               step.next_mode = itl_pkg::MODE_STR_BODY;
            end
            itl_pkg::MODE_STR_BODY: begin
               step.count = 2'd1;
               if (itl_pkg::is_alpha(byte_in) || byte_in == itl_pkg::CH_SPACE) begin
                  step.res0 = itl_pkg::make_result(itl_pkg::KIND_STRING, byte_in, 1'b1, 1'b0);
               end else if (byte_in == itl_pkg::CH_QUOTE) begin
                  step.res0      = itl_pkg::make_result(itl_pkg::KIND_STRING, '0, 1'b0, 1'b1);
                  step.next_mode = itl_pkg::MODE_IDLE;
               end else begin
                  step.res0      = itl_pkg::make_result(itl_pkg::KIND_UNTERM, '0, 1'b0, 1'b1);
                  step.next_mode = itl_pkg::MODE_ERROR;
               end
            end
            itl_pkg::MODE_ERROR: begin
               step.count = 2'd0;
            end
            default: begin
               step.res0      = idle.res;
               step.count     = idle.emit ? 2'd1 : 2'd0;
               step.next_mode = idle.mode;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ini_token_lexer.sv =====
// INI token lexer
// req_if carries one item per handshake: op (data byte or end of input) and byte_in.
// rsp_if carries the token stream: token_kind, char_out, char_valid, token_done.
// Both channels move an item on a clock edge where valid and ready are high.
// An accepted item sits in an input register; a one-level combinational lexer
// step turns it into zero, one or two results that are loaded into the output
// register one per cycle while rsp ready lets the output register drain.
// The first result of an item is loaded from the input register into the output
// register once that register is free, and then shows on rsp_if.
// Throughput: one item per cycle when each makes at most one result and rsp
// ready stays high; an item that makes two (a closing marker plus a new token,
// or a closing marker plus END) waits on the single output register for both.
// Reset (synchronous, active high) empties both registers and returns the
// lexer to idle.
// When the receiver holds rsp ready low the output register keeps its result, and
// an item that makes results holds the input register and req ready low.
`default_nettype none

module ini_token_lexer (
   input  var logic  clock,
   input  var logic  reset,
   itl_req_if.sink   req_if,
   itl_rsp_if.source rsp_if
);

   logic                          stage_valid_ff;
   logic                          stage_valid_in;
   logic                          stage_op_ff;
   logic [itl_pkg::CharWidth-1:0] stage_byte_ff;
   logic                          second_ff;
   logic                          second_in;
   itl_pkg::mode_type             mode_ff;
   itl_pkg::mode_type             mode_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   itl_pkg::result_type           rsp_ff;
   itl_pkg::result_type           rsp_in;

   itl_pkg::step_type             step;
   logic                          out_free;
   logic                          stage_done;
   logic                          emit;
   logic                          take;

   itl_classify u_classify (
      .mode    (mode_ff),
      .op      (stage_op_ff),
      .byte_in (stage_byte_ff),
      .step    (step)
   );

   always_comb begin
      out_free   = !rsp_valid_ff || rsp_if.ready;
      emit       = stage_valid_ff && out_free && step.count != 2'd0;
      stage_done = stage_valid_ff &&
                   (step.count == 2'd0 ||
                    (out_free && (step.count == 2'd1 || second_ff)));
      take       = req_if.valid && req_if.ready;

      stage_valid_in = take ? 1'b1 : (stage_done ? 1'b0 : stage_valid_ff);
      mode_in        = stage_done ? step.next_mode : mode_ff;
      // second result of a two-result item goes out once the first has been loaded
      if (stage_done) begin
         second_in = 1'b0;
      end else if (emit) begin
         second_in = 1'b1;
      end else begin
         second_in = second_ff;
      end

      rsp_valid_in = emit ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);
      rsp_in       = second_ff ? step.res1 : step.res0;
   end

   assign req_if.ready       = !stage_valid_ff || stage_done;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.token_kind  = rsp_ff.kind;
   assign rsp_if.char_out    = rsp_ff.ch;
   assign rsp_if.char_valid  = rsp_ff.ch_valid;
   assign rsp_if.token_done  = rsp_ff.done;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         second_ff      <= 1'b0;
         mode_ff        <= itl_pkg::MODE_IDLE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         second_ff      <= second_in;
         mode_ff        <= mode_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stage_op_ff   <= req_if.op;
         stage_byte_ff <= req_if.byte_in;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
import itl_pkg::*;

class token_scoreboard;
   mode_type    mode;
   result_type  expected_tokens[$];
   int unsigned failures;
   int unsigned checked;
   int unsigned kind_hits[16];

   function new();
      mode     = MODE_IDLE;
      failures = 0;
      checked  = 0;
      foreach (kind_hits[i]) kind_hits[i] = 0;
   endfunction

   function bit is_alpha_char(logic [CharWidth-1:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function bit is_numeric(logic [CharWidth-1:0] c);
      return (c >= 8'h30 && c <= 8'h39) || c == CH_DOT;
   endfunction

   function void emit(kind_type k, logic [CharWidth-1:0] c, logic v, logic d);
      result_type r;
      r.kind     = k;
      r.ch       = c;
      r.ch_valid = v;
      r.done     = d;
      expected_tokens.insert(expected_tokens.size(), r);
   endfunction

   // a byte seen with no token open
   function void lex_fresh(logic [CharWidth-1:0] c);
      case (c)
         CH_SPACE, CH_TAB, CH_CR: ;
         CH_LF:     emit(KIND_NEWLINE, c, 1'b1, 1'b1);
         CH_LBRACK: emit(KIND_LBRACK, c, 1'b1, 1'b1);
         CH_RBRACK: emit(KIND_RBRACK, c, 1'b1, 1'b1);
         CH_EQUALS: emit(KIND_EQUALS, c, 1'b1, 1'b1);
         CH_QUOTE:  mode = MODE_STR_OPEN;
         default: begin
            if (is_alpha_char(c)) begin
               emit(KIND_ID, c, 1'b1, 1'b0);
               mode = MODE_ID;
            end else if (is_numeric(c)) begin
               emit(KIND_NUM, c, 1'b1, 1'b0);
               mode = MODE_NUM;
            end else begin
               emit(KIND_BADCHAR, c, 1'b1, 1'b1);
               mode = MODE_ERROR;
            end
         end
      endcase
   endfunction

   function void note_item(op_type op, logic [CharWidth-1:0] c);
      if (op == OP_END) begin
         case (mode)
            MODE_ID:                      emit(KIND_ID, 8'h00, 1'b0, 1'b1);
            MODE_NUM:                     emit(KIND_NUM, 8'h00, 1'b0, 1'b1);
            MODE_STR_OPEN, MODE_STR_BODY: emit(KIND_UNTERM, 8'h00, 1'b0, 1'b1);
            default: ;
         endcase
         emit(KIND_END, 8'h00, 1'b0, 1'b1);
         mode = MODE_IDLE;
         return;
      end
      case (mode)
         MODE_ID: begin
            if (is_alpha_char(c)) begin
               emit(KIND_ID, c, 1'b1, 1'b0);
            end else begin
               emit(KIND_ID, 8'h00, 1'b0, 1'b1);
               mode = MODE_IDLE;
               lex_fresh(c);
            end
         end
         MODE_NUM: begin
            if (is_numeric(c)) begin
               emit(KIND_NUM, c, 1'b1, 1'b0);
            end else begin
               emit(KIND_NUM, 8'h00, 1'b0, 1'b1);
               mode = MODE_IDLE;
               lex_fresh(c);
            end
         end
         // first character after the quote is taken as is
         MODE_STR_OPEN: begin
            emit(KIND_STRING, c, 1'b1, 1'b0);
            mode = MODE_STR_BODY;
         end
         MODE_STR_BODY: begin
            if (is_alpha_char(c) || c == CH_SPACE) begin
               emit(KIND_STRING, c, 1'b1, 1'b0);
            end else if (c == CH_QUOTE) begin
               emit(KIND_STRING, 8'h00, 1'b0, 1'b1);
               mode = MODE_IDLE;
            end else begin
               emit(KIND_UNTERM, 8'h00, 1'b0, 1'b1);
               mode = MODE_ERROR;
            end
         end
         MODE_ERROR: ;
         default: begin
            mode = MODE_IDLE;
            lex_fresh(c);
         end
      endcase
   endfunction

   function void check_result(result_type got);
      result_type want;
      if (expected_tokens.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("%0t: unexpected token kind %0d ch %h valid %b done %b",
                     $time, got.kind, got.ch, got.ch_valid, got.done);
         return;
      end
      want = expected_tokens.pop_front();
      checked++;
      kind_hits[want.kind]++;
      if (got.kind !== want.kind || got.ch !== want.ch || got.ch_valid !== want.ch_valid ||
          got.done !== want.done) begin
         failures++;
         if (failures <= 10) begin
            $display("%0t: token mismatch, expected kind %0d ch %h valid %b done %b",
                     $time, want.kind, want.ch, want.ch_valid, want.done);
            $display("%0t:                 got kind %0d ch %h valid %b done %b",
                     $time, got.kind, got.ch, got.ch_valid, got.done);
         end
      end
   endfunction

   function int unsigned outstanding();
      return expected_tokens.size();
   endfunction
endclass

module tb;
   localparam int unsigned ItemTarget = 1500;
   localparam int unsigned HoldCycles = 150;
   localparam int unsigned StallLimit = 2000;
   localparam int unsigned TailCycles = 20;

   logic clock = 1'b0;
   logic reset;

   itl_req_if req_ch ();
   itl_rsp_if rsp_ch ();

   ini_token_lexer dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   token_scoreboard sb = new();

   int unsigned items_sent   = 0;
   int unsigned streams      = 0;
   int unsigned burst_left   = 0;
   bit          steady_phase = 1'b0;
   bit          hold_request = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic send_item(op_type op, logic [CharWidth-1:0] c);
      int unsigned gap;
      gap = (steady_phase || burst_left != 0) ? 0 : $urandom_range(0, 10);
      if (burst_left != 0) burst_left--;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.op      <= op;
      req_ch.byte_in <= c;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_item(op, c);
      items_sent++;
      if (op == OP_END) streams++;
   endtask

   task automatic send_data(logic [CharWidth-1:0] c);
      send_item(OP_DATA, c);
   endtask

   task automatic send_end();
      send_item(OP_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_data(s[i]);
   endtask

   function automatic logic [CharWidth-1:0] rand_letter();
      int unsigned k;
      k = $urandom_range(0, 51);
      return (k < 26) ? 8'(8'h61 + k) : 8'(8'h41 + k - 26);
   endfunction

   function automatic logic [CharWidth-1:0] rand_numeric();
      int unsigned k;
      k = $urandom_range(0, 10);
      return (k == 10) ? CH_DOT : 8'(8'h30 + k);
   endfunction

   task automatic send_ident();
      repeat ($urandom_range(1, 6)) send_data(rand_letter());
   endtask

   task automatic send_number();
      repeat ($urandom_range(1, 5)) send_data(rand_numeric());
   endtask

   task automatic send_blanks();
      int unsigned k;
      repeat ($urandom_range(0, 2)) begin
         k = $urandom_range(0, 2);
         send_data(k == 0 ? CH_SPACE : (k == 1 ? CH_TAB : CH_CR));
      end
   endtask

   task automatic send_string(bit closed);
      send_data(CH_QUOTE);
      if ($urandom_range(0, 3) == 0) send_data(rand_letter());
      else send_data(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 5))
         send_data($urandom_range(0, 4) == 0 ? CH_SPACE : rand_letter());
      if (closed) send_data(CH_QUOTE);
      else if ($urandom_range(0, 1) == 1) send_data(8'($urandom_range(0, 255)));
   endtask

   task automatic send_line();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         send_data(CH_LBRACK);
         send_ident();
         send_data(CH_RBRACK);
         send_blanks();
         send_data(CH_LF);
      end else if (pick < 60) begin
         send_ident();
         send_blanks();
         send_data(CH_EQUALS);
         send_blanks();
         case ($urandom_range(0, 2))
            0:       send_number();
            1:       send_ident();
            default: send_string($urandom_range(0, 9) != 0);
         endcase
         send_blanks();
         send_data(CH_LF);
      end else if (pick < 70) begin
         send_blanks();
         send_data(CH_LF);
      end else if (pick < 80) begin
         send_string($urandom_range(0, 1) == 1);
         send_data(CH_LF);
      end else if (pick < 90) begin
         repeat ($urandom_range(1, 4)) send_data(8'($urandom_range(0, 255)));
      end else begin
         // tokens glued together so each one closes on the next one's first byte
         send_number();
         send_ident();
         send_number();
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // response side
   initial begin
      int unsigned stall;
      result_type  got;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end else begin
            stall = steady_phase ? 0 : $urandom_range(0, 10);
            if (stall != 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         got.kind     = kind_type'(rsp_ch.token_kind);
         got.ch       = rsp_ch.char_out;
         got.ch_valid = rsp_ch.char_valid;
         got.done     = rsp_ch.token_done;
         sb.check_result(got);
      end
   end

   initial begin
      int unsigned dead_cycles;
      dead_cycles = 0;
      while (dead_cycles < StallLimit) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            dead_cycles = 0;
         else
            dead_cycles++;
      end
      $display("no progress for %0d cycles", StallLimit);
      $display("ini_token_lexer test failed");
      $finish;
   end

   initial begin
      bit hold_done;
      bit drain_done;
      hold_done      = 1'b0;
      drain_done     = 1'b0;
      req_ch.valid   <= 1'b0;
      req_ch.op      <= OP_DATA;
      req_ch.byte_in <= 8'h00;
      reset          <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // single tokens and a simple section
      send_text("[a]");
      send_data(CH_LF);
      // equals closes the identifier, space closes the number
      send_text("k=1.");
      send_data(CH_SPACE);
      // a quote right after the opening quote is the first character
      send_data(CH_QUOTE);
      send_data(CH_QUOTE);
      send_text("x ");
      send_data(CH_QUOTE);
      // skipped blanks, number closed by end of input
      send_data(CH_TAB);
      send_data(CH_CR);
      send_text("9");
      send_item(OP_END, 8'hFF);
      // identifier closed by a bad byte, then silence until end
      send_text("z");
      send_data(8'hFF);
      send_text("a");
      send_item(OP_END, 8'h00);
      // any byte opens the string, a digit breaks it
      send_data(CH_QUOTE);
      send_data(8'h00);
      send_text("1");
      send_end();
      // string left open at end of input
      send_data(CH_QUOTE);
      send_end();
      wait_drained();

      while (items_sent < ItemTarget) begin
         steady_phase = ($urandom_range(0, 4) == 0);
         repeat ($urandom_range(1, 6)) send_line();
         if (!hold_done && items_sent >= ItemTarget / 3) begin
            // receiver stalls while the sender keeps pushing
            hold_done    = 1'b1;
            hold_request = 1'b1;
            burst_left   = 80;
         end
         send_end();
         if (!drain_done && items_sent >= 2 * ItemTarget / 3) begin
            drain_done = 1'b1;
            wait_drained();
         end else if ($urandom_range(0, 9) == 0) begin
            wait_drained();
         end
      end

      wait_drained();
      repeat (TailCycles) @(posedge clock);
      $display("sent %0d items in %0d streams, checked %0d tokens",
               items_sent, streams, sb.checked);
      $display("by kind: end %0d id %0d num %0d string %0d bad %0d unterminated %0d",
               sb.kind_hits[KIND_END], sb.kind_hits[KIND_ID], sb.kind_hits[KIND_NUM],
               sb.kind_hits[KIND_STRING], sb.kind_hits[KIND_BADCHAR],
               sb.kind_hits[KIND_UNTERM]);
      if (sb.failures == 0 && sb.outstanding() == 0) begin
         $display("ini_token_lexer test passed");
      end else begin
         $display("%0d failures, %0d tokens never seen", sb.failures, sb.outstanding());
         $display("ini_token_lexer test failed");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
hw/rtl/itl_pkg.sv
hw/rtl/itl_stream_if.sv
hw/rtl/itl_classify.sv
hw/rtl/ini_token_lexer.sv
verif/tb.sv
